@@ hdl/sprite_run_code_emitter_unit_macros.svh @@
// Assertion helpers for the sprite run code emitter.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SPRITE_RUN_CODE_EMITTER_UNIT_MACROS_SVH
`define SPRITE_RUN_CODE_EMITTER_UNIT_MACROS_SVH

// Same-cycle implication
`define SRE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sre_pkg.sv @@
package sre_pkg;

  // Fixed field and port widths
  localparam int UPC_W       = 4;
  localparam int UCODE_DEPTH = 9;
  localparam int LW_W        = 10;
  localparam int PSC_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  // Request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd1;

  // Size index codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  // Reset values of the configuration registers
  localparam logic [PSC_W-1:0] PSC_RESET = 2'd1;
  localparam logic [LW_W-1:0]  LW_RESET  = 10'd512;

  // Instruction codes
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_LOAD_B  = 4'd1;
  localparam logic [3:0] OP_ZEXT_B  = 4'd4;
  localparam logic [3:0] OP_STORE_B = 4'd6;
  localparam logic [3:0] OP_SUB     = 4'd9;
  localparam logic [3:0] OP_RET     = 4'd10;
  localparam logic [3:0] OP_NOP     = 4'd11;

  // Register numbers
  localparam logic [3:0] REG_NONE   = 4'd0;
  localparam logic [3:0] REG_PIX    = 4'd0;
  localparam logic [3:0] REG_SRC    = 4'd4;
  localparam logic [3:0] REG_DST    = 4'd5;
  localparam logic [3:0] REG_STRIDE = 4'd6;

  // Pixel masks
  localparam logic [31:0] PIX_ALPHA    = 32'h0;
  localparam logic [31:0] MASK_BYTE    = 32'hFF;
  localparam logic [31:0] MASK_WORD    = 32'hFFFF;
  localparam logic [31:0] ZX_MASK_BYTE = 32'h80;
  localparam logic [31:0] ZX_MASK_WORD = 32'h8000;

  // Chunk limits of the run adds
  localparam int SRC_CHUNK = 127;
  localparam int DST_CHUNK = 128;
  localparam logic signed [7:0] A_SRC_MAX = 8'sh7F;
  localparam logic signed [7:0] A_DST_MAX = 8'sh80;
  localparam logic signed [7:0] A_ZERO    = 8'sh00;

  // Microcode addresses
  localparam logic [UPC_W-1:0] ADR_START     = 4'd0;
  localparam logic [UPC_W-1:0] ADR_FLUSH_SRC = 4'd1;
  localparam logic [UPC_W-1:0] ADR_FLUSH_DST = 4'd2;
  localparam logic [UPC_W-1:0] ADR_LOAD      = 4'd3;
  localparam logic [UPC_W-1:0] ADR_ZEXT      = 4'd4;
  localparam logic [UPC_W-1:0] ADR_STORE     = 4'd5;
  localparam logic [UPC_W-1:0] ADR_SUB       = 4'd6;
  localparam logic [UPC_W-1:0] ADR_RET       = 4'd7;
  localparam logic [UPC_W-1:0] ADR_NOP       = 4'd8;

  typedef enum logic [1:0] {
    ASEL_IMM,
    ASEL_SRC,
    ASEL_DST
  } asel_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_TRANSPARENT,
    COND_NO_ZEXT,
    COND_NO_EOL
  } cond_t;

  typedef struct packed {
    logic [3:0]        op;
    logic              sized;
    asel_t             asel;
    logic signed [7:0] imm_a;
    logic [3:0]        reg_b;
    cond_t             jmp_cond;
    logic [UPC_W-1:0]  jmp_target;
    cond_t             end_cond;
  } ucode_word_t;

  typedef struct packed {
    logic             go;
    logic [UPC_W-1:0] entry;
  } launch_t;

  typedef struct packed {
    logic transparent;
    logic no_zext;
    logic no_eol;
    logic chunk_last;
  } status_t;

  typedef struct packed {
    logic        fire;
    logic        end_hit;
    ucode_word_t word;
  } ctl_t;

  function automatic logic cond_true(cond_t c, status_t s);
    logic r;
    unique case (c)
      COND_NEVER:       r = 1'b0;
      COND_ALWAYS:      r = 1'b1;
      COND_TRANSPARENT: r = s.transparent;
      COND_NO_ZEXT:     r = s.no_zext;
      COND_NO_EOL:      r = s.no_eol;
      default:          r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/sre_ucode_rom.sv @@
module sre_ucode_rom
  import sre_pkg::*;
(
  input  logic [UPC_W-1:0] addr,
  output ucode_word_t      word
);

  // Control store: one word per step
  always_comb begin
    unique case (addr)
      // line stride setup, chunks of -128 into the stride register
      ADR_START: word = '{op: OP_ADD, sized: 1'b0, asel: ASEL_DST, imm_a: A_ZERO,
                          reg_b: REG_STRIDE, jmp_cond: COND_NEVER, jmp_target: ADR_START,
                          end_cond: COND_ALWAYS};
      // run flush, source side
      ADR_FLUSH_SRC: word = '{op: OP_ADD, sized: 1'b0, asel: ASEL_SRC, imm_a: A_ZERO,
                              reg_b: REG_SRC, jmp_cond: COND_NEVER,
                              jmp_target: ADR_FLUSH_SRC, end_cond: COND_NEVER};
      // run flush, destination side; transparent pixel goes to line end
      ADR_FLUSH_DST: word = '{op: OP_ADD, sized: 1'b0, asel: ASEL_DST, imm_a: A_ZERO,
                              reg_b: REG_DST, jmp_cond: COND_TRANSPARENT,
                              jmp_target: ADR_SUB, end_cond: COND_NEVER};
      ADR_LOAD: word = '{op: OP_LOAD_B, sized: 1'b1, asel: ASEL_IMM, imm_a: 8'sd4,
                         reg_b: REG_PIX, jmp_cond: COND_NO_ZEXT, jmp_target: ADR_STORE,
                         end_cond: COND_NEVER};
      ADR_ZEXT: word = '{op: OP_ZEXT_B, sized: 1'b1, asel: ASEL_IMM, imm_a: A_ZERO,
                         reg_b: REG_PIX, jmp_cond: COND_NEVER, jmp_target: ADR_ZEXT,
                         end_cond: COND_NEVER};
      ADR_STORE: word = '{op: OP_STORE_B, sized: 1'b1, asel: ASEL_IMM, imm_a: A_ZERO,
                          reg_b: REG_DST, jmp_cond: COND_NEVER, jmp_target: ADR_STORE,
                          end_cond: COND_NO_EOL};
      ADR_SUB: word = '{op: OP_SUB, sized: 1'b0, asel: ASEL_IMM, imm_a: 8'sd6,
                        reg_b: REG_DST, jmp_cond: COND_NEVER, jmp_target: ADR_SUB,
                        end_cond: COND_ALWAYS};
      ADR_RET: word = '{op: OP_RET, sized: 1'b0, asel: ASEL_IMM, imm_a: A_ZERO,
                        reg_b: REG_NONE, jmp_cond: COND_NEVER, jmp_target: ADR_RET,
                        end_cond: COND_NEVER};
      ADR_NOP: word = '{op: OP_NOP, sized: 1'b0, asel: ASEL_IMM, imm_a: A_ZERO,
                        reg_b: REG_NONE, jmp_cond: COND_NEVER, jmp_target: ADR_NOP,
                        end_cond: COND_ALWAYS};
      default: word = '{op: OP_NOP, sized: 1'b0, asel: ASEL_IMM, imm_a: A_ZERO,
                        reg_b: REG_NONE, jmp_cond: COND_NEVER, jmp_target: ADR_NOP,
                        end_cond: COND_ALWAYS};
    endcase
  end

endmodule

@@ hdl/sre_sequencer.sv @@
module sre_sequencer
  import sre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  launch_t          launch,
  input  status_t          status,
  input  logic             out_free,
  output ctl_t             ctl,
  output logic             busy,
  output logic [UPC_W-1:0] upc
);

  ucode_word_t word;
  logic        step_done;
  logic        jump;

  sre_ucode_rom u_rom (
    .addr (upc),
    .word (word)
  );

  // Issue a step when the output register can take a result
  always_comb begin
    ctl.word    = word;
    ctl.fire    = busy && out_free;
    step_done   = ctl.fire && status.chunk_last;
    ctl.end_hit = step_done && cond_true(word.end_cond, status);
    jump        = cond_true(word.jmp_cond, status);
  end

  // Step counter: load entry on accept, stop at program end, hold inside a chunk loop, branch or advance
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= ADR_START;
    end else if (in_fire && launch.go) begin
      busy <= 1'b1;
      upc  <= launch.entry;
    end else if (ctl.end_hit) begin
      busy <= 1'b0;
    end else if (step_done) begin
      upc <= jump ? word.jmp_target : upc + UPC_W'(1);
    end
  end

endmodule

@@ hdl/sre_datapath.sv @@
module sre_datapath
  import sre_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 512,
  parameter int COL_W          = 9,
  parameter int RUN_W          = 10,
  parameter int BYTES_W        = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic [1:0]            req_type,
  input  logic [31:0]           pixel_value,
  input  ctl_t                  ctl,
  input  logic                  out_ready,
  output launch_t               launch,
  output status_t               status,
  output logic                  out_free,
  output logic                  out_valid,
  output logic [3:0]            op_kind,
  output logic signed [7:0]     operand_a,
  output logic [3:0]            operand_b,
  output logic                  last_of_run
);

  logic [PSC_W-1:0]  pixel_size_code;
  logic [LW_W-1:0]   line_width;
  logic [COL_W-1:0]  column_count;
  logic [RUN_W-1:0]  transparent_run;

  logic [1:0]        si;
  logic [1:0]        si_q;
  logic [LW_W-1:0]   w;
  logic [LW_W-1:0]   w_m1;
  logic [31:0]       used;
  logic              eol;
  logic              used_zero;
  logic              zx;
  logic              do_flush;
  logic [RUN_W-1:0]  run_inc;
  logic [RUN_W-1:0]  run_flush;
  logic [BYTES_W-1:0] start_bytes;
  logic [BYTES_W-1:0] flush_bytes;
  logic [BYTES_W-1:0] rem;
  logic [BYTES_W-1:0] rem_next;
  logic [BYTES_W-1:0] run_bytes;
  logic              transparent_q;
  logic              zx_q;
  logic              eol_q;
  logic              rem_gt_src;
  logic              rem_gt_dst;
  logic signed [7:0] a_val;

  // Decode the item against the current line state
  always_comb begin
    si = (pixel_size_code >= SIZE_LONG) ? SIZE_LONG : pixel_size_code;
    if (line_width == '0) begin
      w = LW_W'(1);
    end else if (line_width > LW_W'(MAX_LINE_WIDTH)) begin
      w = LW_W'(MAX_LINE_WIDTH);
    end else begin
      w = line_width;
    end
    w_m1 = w - LW_W'(1);
    eol  = LW_W'(column_count) >= w_m1;
    unique case (si)
      SIZE_BYTE: begin
        used = pixel_value & MASK_BYTE;
        zx   = (used & ZX_MASK_BYTE) != '0;
      end
      SIZE_WORD: begin
        used = pixel_value & MASK_WORD;
        zx   = (used & ZX_MASK_WORD) != '0;
      end
      default: begin
        used = pixel_value;
        zx   = 1'b0;
      end
    endcase
    used_zero   = used == PIX_ALPHA;
    run_inc     = transparent_run + RUN_W'(1);
    run_flush   = used_zero ? run_inc : transparent_run;
    do_flush    = used_zero ? eol : (transparent_run != '0);
    flush_bytes = BYTES_W'(run_flush) << si;
    start_bytes = BYTES_W'(w) << si;
  end

  // Pick the program entry
  always_comb begin
    launch.go    = 1'b0;
    launch.entry = ADR_START;
    unique case (req_type)
      REQ_START: begin
        launch.go    = 1'b1;
        launch.entry = ADR_START;
      end
      REQ_PIXEL: begin
        launch.go    = do_flush || !used_zero;
        launch.entry = do_flush ? ADR_FLUSH_SRC : ADR_LOAD;
      end
      REQ_FINISH: begin
        launch.go    = 1'b1;
        launch.entry = ADR_RET;
      end
      default: begin
        launch.go    = 1'b0;
        launch.entry = ADR_START;
      end
    endcase
  end

  // Chunk the pending byte count
  always_comb begin
    rem_gt_src = rem > BYTES_W'(SRC_CHUNK);
    rem_gt_dst = rem > BYTES_W'(DST_CHUNK);
    rem_next   = rem;
    unique case (ctl.word.asel)
      ASEL_SRC: begin
        a_val             = rem_gt_src ? A_SRC_MAX : signed'(rem[7:0]);
        status.chunk_last = !rem_gt_src;
        rem_next          = rem_gt_src ? rem - BYTES_W'(SRC_CHUNK) : run_bytes;
      end
      ASEL_DST: begin
        a_val             = rem_gt_dst ? A_DST_MAX : signed'(8'd0 - rem[7:0]);
        status.chunk_last = !rem_gt_dst;
        rem_next          = rem_gt_dst ? rem - BYTES_W'(DST_CHUNK) : rem;
      end
      default: begin
        a_val             = ctl.word.imm_a;
        status.chunk_last = 1'b1;
      end
    endcase
    status.transparent = transparent_q;
    status.no_zext     = !zx_q;
    status.no_eol      = !eol_q;
    out_free           = !out_valid || out_ready;
  end

  // Config, line state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_size_code <= PSC_RESET;
      line_width      <= LW_RESET;
      column_count    <= '0;
      transparent_run <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PIXEL_SIZE) begin
          pixel_size_code <= cfg_data[PSC_W-1:0];
        end else if (cfg_index == CFG_LINE_WIDTH) begin
          line_width <= cfg_data[LW_W-1:0];
        end
      end
      if (in_fire) begin
        unique case (req_type)
          REQ_PIXEL: begin
            column_count    <= eol ? '0 : column_count + COL_W'(1);
            transparent_run <= (used_zero && !eol) ? run_inc : '0;
          end
          REQ_START, REQ_FINISH: begin
            column_count    <= '0;
            transparent_run <= '0;
          end
          default: begin
            column_count    <= column_count;
          end
        endcase
      end
      if (ctl.fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch item flags and byte counts; load the result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      si_q          <= si;
      transparent_q <= used_zero;
      zx_q          <= zx;
      eol_q         <= eol;
      run_bytes     <= flush_bytes;
      rem           <= (req_type == REQ_START) ? start_bytes : flush_bytes;
    end else if (ctl.fire) begin
      rem <= rem_next;
    end
    if (ctl.fire) begin
      op_kind     <= ctl.word.sized ? ctl.word.op + {2'b00, si_q} : ctl.word.op;
      operand_a   <= a_val;
      operand_b   <= ctl.word.reg_b;
      last_of_run <= ctl.end_hit;
    end
  end

endmodule

@@ hdl/sprite_run_code_emitter_unit.sv @@
// Sprite run code emitter: pixel stream in, blit instruction stream out.
// An accepted item loads the microcode step counter; each step loads the result register.
// Throughput: one result per cycle while the result register is free; no new item is
//   accepted until the program of the last one has ended; an item with no result starts none.
// Reset: rst synchronous; clears line state and handshakes, size code two bytes,
//   line width 512.
`include "sprite_run_code_emitter_unit_macros.svh"

module sprite_run_code_emitter_unit
  import sre_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [31:0]           pixel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            op_kind,
  output logic signed [7:0]     operand_a,
  output logic [3:0]            operand_b,
  output logic                  last_of_run
);

  localparam int COL_W     = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int RUN_W     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int BYTES_RAW = $clog2(MAX_LINE_WIDTH * 4 + 1);
  localparam int BYTES_W   = (BYTES_RAW > 8) ? BYTES_RAW : 8;

  launch_t          launch;
  status_t          status;
  ctl_t             ctl;
  logic             busy;
  logic [UPC_W-1:0] upc;
  logic             out_free;
  logic             in_fire;

  // Accept items only between programs
  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;

  sre_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .launch   (launch),
    .status   (status),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy),
    .upc      (upc)
  );

  sre_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .COL_W          (COL_W),
    .RUN_W          (RUN_W),
    .BYTES_W        (BYTES_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .req_type    (req_type),
    .pixel_value (pixel_value),
    .ctl         (ctl),
    .out_ready   (out_ready),
    .launch      (launch),
    .status      (status),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .op_kind     (op_kind),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .last_of_run (last_of_run)
  );

  `SRE_ASSERT_SAME(a_upc_range, busy, upc < UPC_W'(UCODE_DEPTH), "step counter out of range")
  `SRE_ASSERT_SAME(a_no_overwrite, ctl.fire, !out_valid || out_ready, "result overwritten")
  `SRE_ASSERT_NEXT(a_end_idle, ctl.fire && ctl.end_hit, !busy, "program end left busy")
  `SRE_ASSERT_NEXT(a_start_busy, in_fire && req_type == REQ_START, busy, "start did not launch")

endmodule

@@ verif/run_code_checker.sv @@
// Watches the three channels of the sprite run code emitter, predicts the
// instruction stream of each accepted item and compares every accepted result
// in order against it.
module run_code_checker
  import sre_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [31:0]           pixel_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [3:0]            op_kind,
  input  logic signed [7:0]     operand_a,
  input  logic [3:0]            operand_b,
  input  logic                  last_of_run,
  output int                    mismatch_count,
  output int                    ops_pending,
  output int                    ops_checked
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] opa;
    logic [3:0] opb;
    logic       last;
  } blit_op_t;

  blit_op_t expected_ops[$];
  blit_op_t item_ops[$];

  // Shadow of the configuration and line state
  logic [PSC_W-1:0] size_code;
  logic [LW_W-1:0]  width_reg;
  logic [8:0]       column;
  int unsigned      run_len;

  int errs;
  int checked;

  task automatic push_op(input logic [3:0] kind, input int a, input logic [3:0] b);
    blit_op_t op;
    op.kind = kind;
    op.opa  = a[7:0];
    op.opb  = b;
    op.last = 1'b0;
    item_ops.push_back(op);
  endtask

  // Split a negative byte offset into adds of at most -128
  task automatic push_dest_adds(input int bytes, input logic [3:0] target);
    int rem;
    rem = bytes;
    while (rem > DST_CHUNK) begin
      push_op(OP_ADD, -DST_CHUNK, target);
      rem -= DST_CHUNK;
    end
    push_op(OP_ADD, -rem, target);
  endtask

  // Skip the pending transparent pixels on source and destination
  task automatic flush_run(input int shift);
    int bytes;
    int rem;
    if (run_len != 0) begin
      bytes = int'(run_len) << shift;
      rem = bytes;
      while (rem > SRC_CHUNK) begin
        push_op(OP_ADD, SRC_CHUNK, REG_SRC);
        rem -= SRC_CHUNK;
      end
      push_op(OP_ADD, rem, REG_SRC);
      push_dest_adds(bytes, REG_DST);
      run_len = 0;
    end
  endtask

  task automatic predict_blit_ops(input logic [1:0] req, input logic [31:0] pix);
    logic [1:0]  si;
    int          shift;
    int          w;
    logic [31:0] used;
    logic        zext;
    blit_op_t    op;
    si    = (size_code >= SIZE_LONG) ? SIZE_LONG : size_code;
    shift = int'(si);
    if (width_reg == 0) w = 1;
    else if (int'(width_reg) > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
    else w = int'(width_reg);
    item_ops.delete();
    case (req)
      REQ_START: begin
        column  = '0;
        run_len = 0;
        push_dest_adds(w << shift, REG_STRIDE);
      end
      REQ_PIXEL: begin
        case (si)
          SIZE_BYTE: used = pix & MASK_BYTE;
          SIZE_WORD: used = pix & MASK_WORD;
          default:   used = pix;
        endcase
        if (used == PIX_ALPHA) begin
          run_len++;
        end else begin
          flush_run(shift);
          push_op(OP_LOAD_B + {2'b00, si}, int'(REG_SRC), REG_PIX);
          zext = (si == SIZE_BYTE && (used & ZX_MASK_BYTE) != 0) ||
                 (si == SIZE_WORD && (used & ZX_MASK_WORD) != 0);
          if (zext) push_op(OP_ZEXT_B + {2'b00, si}, int'(REG_PIX), REG_PIX);
          push_op(OP_STORE_B + {2'b00, si}, int'(REG_PIX), REG_DST);
        end
        // close the line at the last column of the current width
        if (int'(column) >= w - 1) begin
          flush_run(shift);
          push_op(OP_SUB, int'(REG_STRIDE), REG_DST);
          column = '0;
        end else begin
          column = column + 9'd1;
        end
      end
      REQ_FINISH: begin
        column  = '0;
        run_len = 0;
        push_op(OP_RET, int'(A_ZERO), REG_NONE);
        push_op(OP_NOP, int'(A_ZERO), REG_NONE);
      end
      default: ;
    endcase
    foreach (item_ops[i]) begin
      op = item_ops[i];
      op.last = (i == item_ops.size() - 1);
      expected_ops.push_back(op);
    end
  endtask

  always @(posedge clk) begin : watch
    blit_op_t want;
    blit_op_t got;
    if (rst) begin
      size_code = PSC_RESET;
      width_reg = LW_RESET;
      column    = '0;
      run_len   = 0;
      errs      = 0;
      checked   = 0;
      expected_ops.delete();
    end else begin
      // compare results first: a result never belongs to an item of this edge
      if (out_valid && out_ready) begin
        got.kind = op_kind;
        got.opa  = operand_a;
        got.opb  = operand_b;
        got.last = last_of_run;
        checked++;
        if (expected_ops.size() == 0) begin
          errs++;
          if (errs <= REPORT_LIMIT)
            $display("run_code_checker: unexpected op kind %0d a %0d b %0d last %0b",
                     got.kind, $signed(got.opa), got.opb, got.last);
        end else begin
          want = expected_ops.pop_front();
          if (want != got) begin
            errs++;
            if (errs <= REPORT_LIMIT)
              $display({"run_code_checker: op %0d: expected kind %0d a %0d b %0d last %0b,",
                        " got kind %0d a %0d b %0d last %0b"}, checked,
                       want.kind, $signed(want.opa), want.opb, want.last,
                       got.kind, $signed(got.opa), got.opb, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PIXEL_SIZE: size_code = cfg_data[PSC_W-1:0];
          CFG_LINE_WIDTH: width_reg = cfg_data[LW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_blit_ops(req_type, pixel_value);
    end
    mismatch_count <= errs;
    ops_pending    <= expected_ops.size();
    ops_checked    <= checked;
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import sre_pkg::*;

  localparam int MAX_LINE_WIDTH = 512;
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int QUIET_LIMIT    = 1000;
  localparam int N_PHASES       = 9;
  localparam int PHASE_ITEMS    = 36;
  localparam int CALM_FROM      = 7;
  localparam int PRESSURE_PHASE = 4;
  localparam int LONG_RUN_WIDTH = 70;
  localparam int LONG_RUN_LEN   = 69;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            req_type;
  logic [31:0]           pixel_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [3:0]            op_kind;
  logic signed [7:0]     operand_a;
  logic [3:0]            operand_b;
  logic                  last_of_run;

  int         mismatches;
  int         pending;
  int         checked;
  int         items_sent;
  int         reg_writes;
  int         quiet;
  logic       noisy;
  logic [1:0] cur_size;
  int         run_left;

  sprite_run_code_emitter_unit #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) dut (.*);

  run_code_checker #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_run_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .req_type, .pixel_value,
    .out_valid, .out_ready, .op_kind, .operand_a, .operand_b, .last_of_run,
    .mismatch_count(mismatches), .ops_pending(pending), .ops_checked(checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts while noisy
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (noisy && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // End the run when no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the item and wait for it to be taken; valid stays high afterward
  task automatic send_item(input logic [1:0] req, input logic [31:0] pix);
    if (noisy && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 17));
    in_valid    <= 1'b1;
    req_type    <= req;
    pixel_value <= pix;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted instruction has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] size_data,
                           input logic [CFG_DATA_W-1:0] width, input bit set_size);
    wait_idle();
    if (set_size) begin
      write_reg(CFG_PIXEL_SIZE, size_data);
      cur_size = size_data[1:0];
    end
    write_reg(CFG_LINE_WIDTH, width);
    // unmapped indexes must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int                    roll;
    bit                    transparent;
    logic [31:0]           pix;
    logic [7:0]            hi;
    logic [1:0]            code;
    logic [CFG_DATA_W-1:0] width;

    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_PIXEL_SIZE;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    req_type    <= REQ_START;
    pixel_value <= '0;
    noisy       = 1'b1;
    cur_size    = PSC_RESET;
    run_left    = 0;
    items_sent  = 0;
    reg_writes  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, word pixels, finish in the middle of a line
    send_item(REQ_START, 32'h0);
    send_item(REQ_PIXEL, 32'h0000_8001);
    send_item(REQ_PIXEL, 32'hFFFF_0000);
    send_item(REQ_PIXEL, 32'h0000_7FFF);
    send_item(REQ_FINISH, 32'hFFFF_FFFF);

    // byte pixels, width zero acts as one; ignored request type
    configure(10'h3FC, 10'd0, 1'b1);
    send_item(REQ_START, 32'h0);
    send_item(REQ_PIXEL, 32'hFFFF_FF80);
    send_item(REQ_PIXEL, 32'h0000_0100);
    send_item(REQ_IGNORED, 32'hA5A5_5A5A);

    // size code three acts as four bytes, width saturates
    configure(10'h003, 10'h3FF, 1'b1);
    send_item(REQ_START, 32'h0);
    send_item(REQ_PIXEL, 32'h8000_0000);
    send_item(REQ_PIXEL, 32'h0);
    send_item(REQ_PIXEL, 32'h0);
    send_item(REQ_PIXEL, 32'hFFFF_FFFF);

    // shrink the width in the middle of a line
    configure(10'h002, 10'd6, 1'b1);
    send_item(REQ_START, 32'h0);
    send_item(REQ_PIXEL, 32'h0000_0001);
    send_item(REQ_PIXEL, 32'h0);
    send_item(REQ_PIXEL, 32'h0);
    configure(10'h0, 10'd3, 1'b0);
    send_item(REQ_PIXEL, 32'h0);
    send_item(REQ_PIXEL, 32'h0000_00FF);
    send_item(REQ_FINISH, 32'h0);

    // Random phases: a start, then mostly pixels with transparent runs
    for (int ph = 0; ph < N_PHASES; ph++) begin
      noisy = (ph < CALM_FROM) && (ph % 3 != 2);
      hi    = 8'($urandom);
      code  = 2'($urandom_range(0, 3));
      case (ph)
        0: begin
          code  = SIZE_LONG;
          width = CFG_DATA_W'(LONG_RUN_WIDTH);
        end
        1: width = 1;
        2: width = CFG_DATA_W'(MAX_LINE_WIDTH);
        default: begin
          case ($urandom_range(0, 5))
            0: width = 0;
            1: width = 10'h3FF;
            2: width = CFG_DATA_W'(MAX_LINE_WIDTH);
            3: width = CFG_DATA_W'($urandom_range(20, 80));
            default: width = CFG_DATA_W'($urandom_range(1, 12));
          endcase
        end
      endcase
      configure({hi, code}, width, 1'b1);
      send_item(REQ_START, $urandom);
      // one long run to cross several chunk boundaries
      if (ph == 0) run_left = LONG_RUN_LEN;
      for (int n = 0; n < PHASE_ITEMS || run_left > 0; n++) begin
        // hold the sender once until the block has drained
        if (ph == PRESSURE_PHASE && n == PHASE_ITEMS / 2) wait_idle();
        roll = $urandom_range(0, 99);
        if (run_left == 0 && roll < 3) begin
          send_item(REQ_FINISH, $urandom);
        end else if (run_left == 0 && roll < 6) begin
          send_item(REQ_START, $urandom);
        end else if (run_left == 0 && roll < 9) begin
          send_item(REQ_IGNORED, $urandom);
          n--;
        end else begin
          pix = $urandom;
          transparent = 1'b0;
          if (run_left > 0) begin
            run_left--;
            transparent = 1'b1;
          end else if (roll < 30) begin
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
                                                   : $urandom_range(0, 5);
            transparent = 1'b1;
          end else if (roll < 50) begin
            pix = pix | ZX_MASK_BYTE | ZX_MASK_WORD;
          end else if (roll < 55) begin
            pix = '1;
          end
          // clear only the bytes the current size uses
          if (transparent) begin
            case (cur_size)
              SIZE_BYTE: pix = pix & ~MASK_BYTE;
              SIZE_WORD: pix = pix & ~MASK_WORD;
              default:   pix = PIX_ALPHA;
            endcase
          end
          send_item(REQ_PIXEL, pix);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d items accepted, %0d instructions checked, %0d register writes",
             items_sent, checked, reg_writes);
    $display("summary: all size codes, widths 0 to 1023, long runs, mid-line width change");
    if (mismatches == 0 && pending == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
